>>> src/msbm_pkg.sv
// shared types and constants for the multi-signature byte matcher
// no dependencies; imported by the table, emitter and top level
package msbm_pkg;

  localparam int NUM_SIGNATURES_DEF   = 8;
  localparam int MAX_SIG_BYTES_DEF    = 32;
  localparam int MAX_BUFFER_BYTES_DEF = 65536;

  // byte offset counter, saturating
  localparam int            POS_W   = 17;
  localparam int            SEEN_W  = POS_W + 1;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  typedef enum logic [1:0] {
    REQ_SIG_BYTE = 2'd0,
    REQ_SIG_LEN  = 2'd1,
    REQ_SCAN     = 2'd2
  } req_t;

  // state update command from the top level to the signature table
  typedef struct packed {
    logic       sig_wr;
    logic       len_wr;
    logic       shift;
    logic [2:0] slot;
    logic [4:0] byte_index;
    logic [7:0] value;
    logic [5:0] sig_length;
  } tbl_cmd_t;

endpackage

>>> src/msbm_sig_table.sv
// signature table, length table and recent byte window with the per-slot compare
// depends on msbm_pkg
module msbm_sig_table #(
  parameter int NUM_SIGNATURES   = msbm_pkg::NUM_SIGNATURES_DEF,
  parameter int MAX_SIG_BYTES    = msbm_pkg::MAX_SIG_BYTES_DEF,
  parameter int MAX_BUFFER_BYTES = msbm_pkg::MAX_BUFFER_BYTES_DEF
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  msbm_pkg::tbl_cmd_t                                  cmd,
  input  logic [msbm_pkg::SEEN_W-1:0]                         seen,
  output logic [NUM_SIGNATURES-1:0]                           hit,
  output logic [NUM_SIGNATURES-1:0][$clog2(MAX_SIG_BYTES+1)-1:0] lens
);
  import msbm_pkg::*;

  localparam int SLOT_IW = (NUM_SIGNATURES > 1) ? $clog2(NUM_SIGNATURES) : 1;
  localparam int BYTE_IW = (MAX_SIG_BYTES > 1) ? $clog2(MAX_SIG_BYTES) : 1;
  localparam int LEN_W   = $clog2(MAX_SIG_BYTES + 1);
  localparam int LIMIT   = (MAX_BUFFER_BYTES < 65536) ? MAX_BUFFER_BYTES : 65536;

  logic [7:0]       sig    [NUM_SIGNATURES][MAX_SIG_BYTES];
  logic [7:0]       recent [MAX_SIG_BYTES];
  logic [LEN_W-1:0] len_sat;
  logic             slot_ok;
  logic             bidx_ok;

  assign slot_ok = 32'(cmd.slot) < NUM_SIGNATURES;
  assign bidx_ok = 32'(cmd.byte_index) < MAX_SIG_BYTES;
  assign len_sat = (32'(cmd.sig_length) > MAX_SIG_BYTES) ? LEN_W'(MAX_SIG_BYTES)
                                                         : LEN_W'(cmd.sig_length);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_SIGNATURES; s++) begin
        lens[s] <= '0;
        for (int k = 0; k < MAX_SIG_BYTES; k++) begin
          sig[s][k] <= '0;
        end
      end
    end else begin
      if (cmd.sig_wr && slot_ok && bidx_ok) begin
        sig[SLOT_IW'(cmd.slot)][BYTE_IW'(cmd.byte_index)] <= cmd.value;
      end
      if (cmd.len_wr && slot_ok) begin
        lens[SLOT_IW'(cmd.slot)] <= len_sat;
      end
    end
  end

  // newest byte at index 0; older bytes only count once seen covers them
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      recent[0] <= cmd.value;
      for (int i = 1; i < MAX_SIG_BYTES; i++) begin
        recent[i] <= recent[i-1];
      end
    end
  end

  always_comb begin
    int                ridx;
    logic              eq;
    logic [SEEN_W-1:0] start;
    for (int s = 0; s < NUM_SIGNATURES; s++) begin
      eq = 1'b1;
      for (int k = 0; k < MAX_SIG_BYTES; k++) begin
        ridx = int'(lens[s]) - 1 - k;
        if (k < int'(lens[s])) begin
          eq = eq & (sig[s][k] == recent[ridx[BYTE_IW-1:0]]);
        end
      end
      start  = seen - SEEN_W'(lens[s]);
      hit[s] = (lens[s] != '0) && (seen >= SEEN_W'(lens[s])) &&
               (start < SEEN_W'(LIMIT)) && eq;
    end
  end

endmodule

>>> src/msbm_emitter.sv
// match emitter: holds one byte's hit set and sends one match beat per cycle while not stalled
// depends on msbm_pkg
module msbm_emitter #(
  parameter int NUM_SIGNATURES = msbm_pkg::NUM_SIGNATURES_DEF,
  parameter int MAX_SIG_BYTES  = msbm_pkg::MAX_SIG_BYTES_DEF
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  logic                                                cand_valid,
  input  logic [NUM_SIGNATURES-1:0]                           cand_hit,
  input  logic [msbm_pkg::SEEN_W-1:0]                         cand_seen,
  input  logic [NUM_SIGNATURES-1:0][$clog2(MAX_SIG_BYTES+1)-1:0] cand_lens,
  output logic                                                cand_take,
  output logic                                                match_valid,
  input  logic                                                match_stall,
  output logic [15:0]                                         match_offset,
  output logic [2:0]                                          match_slot,
  output logic [5:0]                                          match_length,
  output logic                                                last_match
);
  import msbm_pkg::*;

  localparam int SLOT_IW = (NUM_SIGNATURES > 1) ? $clog2(NUM_SIGNATURES) : 1;
  localparam int LEN_W   = $clog2(MAX_SIG_BYTES + 1);

  logic [NUM_SIGNATURES-1:0]             pend_mask;
  logic [SEEN_W-1:0]                     pend_seen;
  logic [NUM_SIGNATURES-1:0][LEN_W-1:0]  pend_lens;
  logic [NUM_SIGNATURES-1:0]             low;
  logic [NUM_SIGNATURES-1:0]             rest;
  logic [NUM_SIGNATURES-1:0]             mask_after;
  logic [SLOT_IW-1:0]                    sel;
  logic                                  out_free;

  assign out_free   = !match_valid || !match_stall;
  assign low        = pend_mask & (~pend_mask + 1'b1);
  assign rest       = pend_mask & ~low;
  assign mask_after = out_free ? rest : pend_mask;
  assign cand_take  = cand_valid && (mask_after == '0);

  // lowest pending slot goes first
  always_comb begin
    sel = '0;
    for (int i = NUM_SIGNATURES - 1; i >= 0; i--) begin
      if (pend_mask[i]) begin
        sel = SLOT_IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_mask <= '0;
    end else if (cand_take) begin
      pend_mask <= cand_hit;
    end else begin
      pend_mask <= mask_after;
    end
  end

  always_ff @(posedge clk) begin
    if (cand_take) begin
      pend_seen <= cand_seen;
      pend_lens <= cand_lens;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_valid <= 1'b0;
    end else if (out_free) begin
      match_valid <= (pend_mask != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && (pend_mask != '0)) begin
      match_offset <= 16'(pend_seen - SEEN_W'(pend_lens[sel]));
      match_slot   <= 3'(sel);
      match_length <= 6'(pend_lens[sel]);
      last_match   <= (rest == '0);
    end
  end

endmodule

>>> src/multi_signature_byte_matcher_top.sv
// Multi-signature byte matcher, top level.
// Usage:
//   data channel (data_valid / data_stall) carries one request beat: a
//   signature byte write, a signature length write, or a scan data byte.
//   match channel (match_valid / match_stall) carries one beat per signature
//   that ends exactly on a scanned byte: start offset, slot, length, and
//   last_match on the final beat for that byte. Beats of one byte come in
//   ascending slot order.
// Path: a scan byte passes the compare stage, the emitter's pending set and
//   the match output register before its first match beat shows.
// Throughput: one request beat per cycle while scan bytes give no more than
//   one match each and match_stall is low; a byte with several matches holds
//   the single match output port for one beat each. Writes never produce beats.
// Stalls: the match beat sits in an output register and the rest of one
//   byte's hit set waits in the emitter; a scanned byte with hits waits in the
//   compare stage. data_stall rises while that byte cannot move on: the
//   emitter still has more than one match left, or any behind a stalled beat.
// Reset (rst, synchronous): clears the signature table, all lengths (every
//   slot disabled), the byte offset and all valid flags; no clearing pass.
// The byte offset returns to zero after a scan beat with last_of_buffer set,
//   and matches starting at offset 65536 or beyond are dropped.
// depends on msbm_pkg, msbm_sig_table, msbm_emitter
module multi_signature_byte_matcher_top #(
  parameter int NUM_SIGNATURES   = msbm_pkg::NUM_SIGNATURES_DEF,
  parameter int MAX_SIG_BYTES    = msbm_pkg::MAX_SIG_BYTES_DEF,
  parameter int MAX_BUFFER_BYTES = msbm_pkg::MAX_BUFFER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [1:0]  req_type,
  input  logic [2:0]  slot,
  input  logic [4:0]  byte_index,
  input  logic [7:0]  value,
  input  logic [5:0]  sig_length,
  input  logic        last_of_buffer,
  output logic        match_valid,
  input  logic        match_stall,
  output logic [15:0] match_offset,
  output logic [2:0]  match_slot,
  output logic [5:0]  match_length,
  output logic        last_match
);
  import msbm_pkg::*;

  localparam int LEN_W = $clog2(MAX_SIG_BYTES + 1);

  logic                                 accept;
  logic                                 is_scan;
  tbl_cmd_t                             cmd;
  logic [POS_W-1:0]                     pos;
  logic [POS_W-1:0]                     pos_next;
  // compare stage: the scanned byte is already in the window
  logic                                 s1_valid;
  logic [SEEN_W-1:0]                    s1_seen;
  logic [NUM_SIGNATURES-1:0]            hit;
  logic [NUM_SIGNATURES-1:0][LEN_W-1:0] lens;
  logic                                 cand_take;

  // byte with hits waits for the emitter; a byte with none just retires
  assign data_stall = s1_valid && (hit != '0) && !cand_take;
  assign accept     = data_valid && !data_stall;

  // request decode
  always_comb begin
    cmd            = '0;
    cmd.slot       = slot;
    cmd.byte_index = byte_index;
    cmd.value      = value;
    cmd.sig_length = sig_length;
    is_scan        = 1'b0;
    unique case (req_t'(req_type))
      REQ_SIG_BYTE: begin
        cmd.sig_wr = accept;
      end
      REQ_SIG_LEN: begin
        cmd.len_wr = accept;
      end
      REQ_SCAN: begin
        is_scan   = 1'b1;
        cmd.shift = accept;
      end
      default: begin
        is_scan = 1'b0;
      end
    endcase
  end

  // offset of the next data byte, saturating, back to zero after the last one
  always_comb begin
    pos_next = pos;
    if (last_of_buffer) begin
      pos_next = '0;
    end else if (pos < POS_MAX) begin
      pos_next = pos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (accept && is_scan) begin
        pos      <= pos_next;
        s1_valid <= 1'b1;
      end else if (!data_stall) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_scan) begin
      s1_seen <= SEEN_W'(pos) + 1'b1;
    end
  end

  msbm_sig_table #(
    .NUM_SIGNATURES  (NUM_SIGNATURES),
    .MAX_SIG_BYTES   (MAX_SIG_BYTES),
    .MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
  ) u_table (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .seen(s1_seen),
    .hit (hit),
    .lens(lens)
  );

  msbm_emitter #(
    .NUM_SIGNATURES(NUM_SIGNATURES),
    .MAX_SIG_BYTES (MAX_SIG_BYTES)
  ) u_emit (
    .clk         (clk),
    .rst         (rst),
    .cand_valid  (s1_valid && (hit != '0)),
    .cand_hit    (hit),
    .cand_seen   (s1_seen),
    .cand_lens   (lens),
    .cand_take   (cand_take),
    .match_valid (match_valid),
    .match_stall (match_stall),
    .match_offset(match_offset),
    .match_slot  (match_slot),
    .match_length(match_length),
    .last_match  (last_match)
  );

  // a stalled data beat always has a compare stage holding it up
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    data_stall |-> s1_valid)
    else $error("data_stall without a byte in the compare stage");

  // a held compare stage keeps its offset
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && data_stall) |=> (s1_valid && $stable(s1_seen)))
    else $error("compare stage lost its byte while stalled");

  // more beats follow a non-final one, in rising slot order
  a_burst_cont: assert property (@(posedge clk) disable iff (rst)
    (match_valid && !match_stall && !last_match) |=>
      (match_valid && (NUM_SIGNATURES > 8 || match_slot > $past(match_slot))))
    else $error("match burst ended early or out of slot order");

  // a disabled slot never reports
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    match_valid |-> (MAX_SIG_BYTES == 64 || match_length != '0))
    else $error("match beat with zero length");

endmodule
